// ===== hdl/kwm_pkg.sv =====
// ---------------------------------------------------------------------------
// kwm_pkg: shared types and constants for the k-way sorted merge
// Beat formats of the item and result channels, the scan word that travels
// along the cell chain, and the control group that drives every cell.
// ---------------------------------------------------------------------------
package kwm_pkg;

  // Default number of list cells in the chain.
  localparam int MAX_LISTS_DEF = 8;

  // Fixed field widths of the channel beats.
  localparam int CFG_W       = 4;
  localparam int IDX_FIELD_W = 3;
  localparam int VALUE_W     = 32;

  // Reset value of the active list count register.
  localparam logic [CFG_W-1:0] ACTIVE_RESET = 4'd8;

  // One input beat: the next value of one list.
  typedef struct packed {
    logic [IDX_FIELD_W-1:0]    list_index;
    logic signed [VALUE_W-1:0] value;
    logic                      is_last_of_list;
    logic                      list_empty;
  } item_t;

  // One output beat: an emitted head.
  typedef struct packed {
    logic signed [VALUE_W-1:0] merged_value;
    logic [IDX_FIELD_W-1:0]    from_list;
    logic                      merge_done;
  } result_t;

  // Running summary that each cell hands to its right neighbor.
  typedef struct packed {
    logic                      found;      // some active head seen so far
    logic                      all_ready;  // every active list has a head or is finished
    logic                      all_done;   // every active list is finished
    logic                      unf_one;    // at least one unfinished active list
    logic                      unf_many;   // two or more unfinished active lists
    logic                      best_last;  // smallest head is its list's last value
    logic signed [VALUE_W-1:0] best_value; // smallest head so far
  } scan_t;

  // Control group broadcast from the sequencer to every cell.
  typedef struct packed {
    logic wr_en;   // an item beat is being taken
    logic pop_en;  // the cell named by the pop index gives up its head
    logic clear;   // end of merge: drop all per-list state
  } cell_ctl_t;

  // Summary entering the first cell of the chain.
  localparam scan_t SCAN_SEED = '{
    found:      1'b0,
    all_ready:  1'b1,
    all_done:   1'b1,
    unf_one:    1'b0,
    unf_many:   1'b0,
    best_last:  1'b0,
    best_value: '0
  };

endpackage

// ===== hdl/kwm_cell.sv =====
// ---------------------------------------------------------------------------
// kwm_cell: one list slot of the merge chain
// Holds the head value and the valid, last and finished flags of one list,
// takes refills and pops, and folds its head into the running scan summary
// that it registers and passes to the next cell every cycle.
// ---------------------------------------------------------------------------
module kwm_cell #(
  parameter int INDEX     = 0,
  parameter int MAX_LISTS = kwm_pkg::MAX_LISTS_DEF,
  parameter int IW        = $clog2(MAX_LISTS),
  parameter int KW        = $clog2(MAX_LISTS + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [KW-1:0]       k_eff,
  input  kwm_pkg::cell_ctl_t  ctl,
  input  kwm_pkg::item_t      wr,
  input  logic [IW-1:0]       pop_idx,
  input  kwm_pkg::scan_t      scan_in,
  input  logic [IW-1:0]       idx_in,
  output kwm_pkg::scan_t      scan_out,
  output logic [IW-1:0]       idx_out,
  output logic                valid,
  output logic                finished
);
  import kwm_pkg::*;

  localparam logic [IW-1:0] MY_IDX = IW'(INDEX);

  logic signed [VALUE_W-1:0] head;
  logic                      last;
  logic                      active;
  logic                      hit;
  logic                      pop_me;
  logic                      mine_unf;
  logic                      take;
  scan_t                     scan_next;
  logic [IW-1:0]             idx_next;

  // This slot takes part only when its list number is below the active count.
  assign active = int'(k_eff) > INDEX;

  // A refill lands only in an empty slot of an unfinished active list.
  assign hit    = ctl.wr_en && active && (int'(wr.list_index) == INDEX) && !valid && !finished;
  assign pop_me = ctl.pop_en && (pop_idx == MY_IDX);

  // Per-list flags; clearing at the end of a merge wins over refills and pops.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= 1'b0;
      last     <= 1'b0;
      finished <= 1'b0;
    end else if (ctl.clear) begin
      valid    <= 1'b0;
      last     <= 1'b0;
      finished <= 1'b0;
    end else if (hit) begin
      if (wr.list_empty) begin
        finished <= 1'b1;
      end else begin
        valid <= 1'b1;
        last  <= wr.is_last_of_list;
      end
    end else if (pop_me) begin
      valid <= 1'b0;
      if (last) begin
        finished <= 1'b1;
        last     <= 1'b0;
      end
    end
  end

  // Head value storage, written on a refill only.
  always_ff @(posedge clk) begin
    if (hit && !wr.list_empty) begin
      head <= wr.value;
    end
  end

  // Fold this slot into the summary; strict less keeps the lower index on ties.
  always_comb begin
    mine_unf = active && !finished;
    take     = active && valid &&
               (!scan_in.found || ($signed(head) < $signed(scan_in.best_value)));

    scan_next            = scan_in;
    scan_next.found      = scan_in.found | take;
    scan_next.all_ready  = scan_in.all_ready & !(active && !valid && !finished);
    scan_next.all_done   = scan_in.all_done & !mine_unf;
    scan_next.unf_many   = scan_in.unf_many | (scan_in.unf_one & mine_unf);
    scan_next.unf_one    = scan_in.unf_one | mine_unf;
    scan_next.best_value = take ? head : scan_in.best_value;
    scan_next.best_last  = take ? last : scan_in.best_last;
    idx_next             = take ? MY_IDX : idx_in;
  end

  // Hand the summary to the neighbor through a register.
  always_ff @(posedge clk) begin
    scan_out <= scan_next;
    idx_out  <= idx_next;
  end

endmodule

// ===== hdl/k_way_sorted_merge.sv =====
// ---------------------------------------------------------------------------
// k_way_sorted_merge: merge of up to MAX_LISTS ascending lists
// Each item beat refills the head of one list. Once every active list holds
// a head or has finished, the smallest head is emitted (lowest list on ties)
// and its slot waits for the next refill, unless it was that list's last
// value. The beat that finishes the last list carries merge_done.
// ---------------------------------------------------------------------------
// Rate: the heads live in a chain of MAX_LISTS cells, and the minimum search
// moves one cell per cycle along it. After an item beat is taken the block
// stalls further item beats until the chain has settled and it has emitted a
// result or gone idle; each further result of the same item, which follows
// when the emitted value ended its list, needs another pass along the chain.
// A result waiting in the output register does not block the next item beat.
// The user must write the active list count over the configuration port only
// while the block is idle; the block does not enforce this. 0 acts as 1 and
// counts above MAX_LISTS act as MAX_LISTS.
module k_way_sorted_merge #(
  parameter int MAX_LISTS = kwm_pkg::MAX_LISTS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      item_valid,
  output logic                      item_stall,
  input  kwm_pkg::item_t            item,
  output logic                      result_valid,
  input  logic                      result_stall,
  output kwm_pkg::result_t          result,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [kwm_pkg::CFG_W-1:0] cfg_data
);
  import kwm_pkg::*;

  localparam int IW = $clog2(MAX_LISTS);
  localparam int KW = $clog2(MAX_LISTS + 1);
  localparam int CW = $clog2(MAX_LISTS + 1);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_t;

  state_t              state;
  state_t              state_next;
  logic [CW-1:0]       cnt;
  logic [CW-1:0]       cnt_next;
  logic [CFG_W-1:0]    active_lists;
  logic [KW-1:0]       k_eff;
  logic                accept;
  logic                settled;
  logic                out_free;
  logic                can_emit;
  logic                emit;
  logic                merge_done;
  cell_ctl_t           ctl;
  scan_t               scan  [MAX_LISTS];
  logic [IW-1:0]       sidx  [MAX_LISTS];
  scan_t               chain_end;
  logic [IW-1:0]       end_idx;
  logic [MAX_LISTS-1:0] valid_vec;
  logic [MAX_LISTS-1:0] fin_vec;

  // Configuration register; always able to take a beat.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_lists <= ACTIVE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      active_lists <= cfg_data;
    end
  end

  // Clamp the configured count into 1 .. MAX_LISTS.
  always_comb begin
    if (active_lists == '0) begin
      k_eff = KW'(1);
    end else if (int'(active_lists) > MAX_LISTS) begin
      k_eff = KW'(MAX_LISTS);
    end else begin
      k_eff = KW'(active_lists);
    end
  end

  // Item channel: a beat is taken only while the chain is idle.
  assign item_stall = (state != ST_IDLE);
  assign accept     = item_valid && !item_stall;

  // Chain of list cells.
  for (genvar i = 0; i < MAX_LISTS; i++) begin : g_cell
    if (i == 0) begin : g_first
      kwm_cell #(
        .INDEX     (i),
        .MAX_LISTS (MAX_LISTS),
        .IW        (IW),
        .KW        (KW)
      ) u_cell (
        .clk      (clk),
        .rst      (rst),
        .k_eff    (k_eff),
        .ctl      (ctl),
        .wr       (item),
        .pop_idx  (end_idx),
        .scan_in  (SCAN_SEED),
        .idx_in   ('0),
        .scan_out (scan[i]),
        .idx_out  (sidx[i]),
        .valid    (valid_vec[i]),
        .finished (fin_vec[i])
      );
    end else begin : g_rest
      kwm_cell #(
        .INDEX     (i),
        .MAX_LISTS (MAX_LISTS),
        .IW        (IW),
        .KW        (KW)
      ) u_cell (
        .clk      (clk),
        .rst      (rst),
        .k_eff    (k_eff),
        .ctl      (ctl),
        .wr       (item),
        .pop_idx  (end_idx),
        .scan_in  (scan[i-1]),
        .idx_in   (sidx[i-1]),
        .scan_out (scan[i]),
        .idx_out  (sidx[i]),
        .valid    (valid_vec[i]),
        .finished (fin_vec[i])
      );
    end
  end

  assign chain_end = scan[MAX_LISTS-1];
  assign end_idx   = sidx[MAX_LISTS-1];

  // The chain output reflects the current slots once the count is reached.
  assign settled    = (state == ST_SCAN) && (cnt == CW'(MAX_LISTS));
  assign out_free   = !result_valid || !result_stall;
  assign can_emit   = settled && !chain_end.all_done && chain_end.all_ready &&
                      chain_end.found;
  assign emit       = can_emit && out_free;
  // The popped list is the last unfinished one and this was its final value.
  assign merge_done = chain_end.best_last && !chain_end.unf_many;

  // Broadcast control to the cells.
  always_comb begin
    ctl.wr_en  = accept;
    ctl.pop_en = emit;
    ctl.clear  = settled && (chain_end.all_done || (emit && merge_done));
  end

  // Sequencer: wait for the chain to settle, then emit, rescan or go idle.
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_SCAN;
          cnt_next   = '0;
        end
      end
      ST_SCAN: begin
        if (!settled) begin
          cnt_next = cnt + CW'(1);
        end else if (chain_end.all_done) begin
          state_next = ST_IDLE;
        end else if (can_emit) begin
          if (out_free) begin
            if (!merge_done && chain_end.best_last) begin
              // A list just ended; the remaining heads may allow another beat.
              cnt_next = '0;
            end else begin
              state_next = ST_IDLE;
            end
          end
        end else begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
        cnt_next   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  // Output register: loaded on an emission, emptied when the beat is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (emit) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      result.merged_value <= chain_end.best_value;
      result.from_list    <= IDX_FIELD_W'(end_idx);
      result.merge_done   <= merge_done;
    end
  end

  // A slot never holds a head of a list that has already finished.
  a_valid_not_finished : assert property (@(posedge clk) disable iff (rst)
    !(|(valid_vec & fin_vec)))
    else $error("slot holds a head and is finished at once");

  // The emitted head comes from an active list.
  a_emit_active : assert property (@(posedge clk) disable iff (rst)
    emit |-> (int'(end_idx) < int'(k_eff)))
    else $error("emitted head from a list outside the active set");

  // The end of a merge leaves no per-list state behind.
  a_clear_empties : assert property (@(posedge clk) disable iff (rst)
    ctl.clear |=> (valid_vec == '0) && (fin_vec == '0))
    else $error("per-list state survived the end of a merge");

  // A pop that does not end its list leaves that slot waiting, so the block idles.
  a_pop_then_idle : assert property (@(posedge clk) disable iff (rst)
    emit && !chain_end.best_last |=> state == ST_IDLE)
    else $error("sequencer kept scanning while a slot waits for a refill");

endmodule
